// File: hw/rtl/page_table_walker_top_macros.svh
// Assertion macros of the page table walker checker.
// Depends on nothing; included by the checker file.
`ifndef PAGE_TABLE_WALKER_TOP_MACROS_SVH
`define PAGE_TABLE_WALKER_TOP_MACROS_SVH

`define PTW_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("page table walker check failed in the same cycle");

`define PTW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("page table walker check failed one cycle later");

`endif

// File: hw/rtl/ptw_pkg.sv
// Types and constants of the page table walker.
// Depends on nothing; used by every other file of the block but the assertion macros.
package ptw_pkg;

   localparam int INDEX_BITS = 9;
   localparam int VPN_W      = 45;
   localparam int PPN_W      = 52;
   localparam int ENTRY_W    = 53;
   localparam int OP_W       = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 6;
   localparam int MOD_CHUNK  = 12;

   localparam logic [OP_W-1:0] OP_QUERY = 2'd0;
   localparam logic [OP_W-1:0] OP_MAP   = 2'd1;
   localparam logic [OP_W-1:0] OP_UNMAP = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ROOT_FRAME = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_FREE = 1'd1;

   localparam logic [CSR_DATA_W-1:0] ROOT_RESET       = 6'd0;
   localparam logic [CSR_DATA_W-1:0] FIRST_FREE_RESET = 6'd1;

   typedef struct packed {
      logic rd;
      logic wr;
   } mem_ctl_type;

   typedef enum logic [7:0] {
      S_CLEAR = 8'b0000_0001,
      S_IDLE  = 8'b0000_0010,
      S_MOD   = 8'b0000_0100,
      S_READ  = 8'b0000_1000,
      S_WAIT  = 8'b0001_0000,
      S_ZERO  = 8'b0010_0000,
      S_LINK  = 8'b0100_0000,
      S_DONE  = 8'b1000_0000
   } state_type;

endpackage

// File: hw/rtl/ptw_req_if.sv
// Request channel of the page table walker: valid, ready and the request word.
// Depends on ptw_pkg.
interface ptw_req_if;
   logic                        valid;
   logic                        ready;
   logic [ptw_pkg::OP_W-1:0]    operation;
   logic [ptw_pkg::VPN_W-1:0]   vpn;
   logic [ptw_pkg::PPN_W-1:0]   ppn;

   modport source (output valid, operation, vpn, ppn, input ready);
   modport sink   (input valid, operation, vpn, ppn, output ready);
endinterface

// File: hw/rtl/ptw_rsp_if.sv
// Response channel of the page table walker: valid, ready and the result word.
// Depends on ptw_pkg.
interface ptw_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        found;
   logic [ptw_pkg::PPN_W-1:0]   result_ppn;
   logic                        status;

   modport source (output valid, found, result_ppn, status, input ready);
   modport sink   (input valid, found, result_ppn, status, output ready);
endinterface

// File: hw/rtl/ptw_store.sv
// Frame store: single-port synchronous memory with a registered read.
// Depends on ptw_pkg.
module ptw_store #(
   parameter int DEPTH  = 32768,
   parameter int ADDR_W = 15
) (
   input  logic                          clock,
   input  ptw_pkg::mem_ctl_type          ctl,
   input  logic [ADDR_W-1:0]             addr,
   input  logic [ptw_pkg::ENTRY_W-1:0]   wdata,
   output logic [ptw_pkg::ENTRY_W-1:0]   rdata
);

   logic [ptw_pkg::ENTRY_W-1:0] mem [DEPTH];
   logic [ptw_pkg::ENTRY_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr) begin
         mem[addr] <= wdata;
      end
      if (ctl.rd) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: hw/rtl/ptw_mod.sv
// Frame number mod frame count: twelve bits per step, or a mask for a power of two.
// Depends on ptw_pkg.
module ptw_mod #(
   parameter int NUM_FRAMES = 64,
   localparam int FRAME_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [ptw_pkg::PPN_W-1:0]   value,
   output logic                        done,
   output logic [FRAME_W-1:0]          result
);

   localparam bit POW2 = (NUM_FRAMES & (NUM_FRAMES - 1)) == 0;

   generate
      if (POW2) begin : g_mask
         logic               done_ff;
         logic [FRAME_W-1:0] res_ff;

         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= start;
            end
         end

         always_ff @(posedge clock) begin
            if (start) begin
               res_ff <= value[FRAME_W-1:0];
            end
         end

         assign done   = done_ff;
         assign result = res_ff;
      end else begin : g_iter
         // Each chunk is folded into the remainder with a reciprocal estimate of the
         // quotient, which is low by at most one, and a single corrective subtract.
         localparam int CHUNK  = ptw_pkg::MOD_CHUNK;
         localparam int CHUNKS = (ptw_pkg::PPN_W + CHUNK - 1) / CHUNK;
         localparam int PAD_W  = CHUNKS * CHUNK;
         localparam int X_W    = FRAME_W + CHUNK;
         localparam int CNT_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
         localparam logic [X_W-1:0] RECIP = X_W'((64'd1 << X_W) / 64'(NUM_FRAMES));

         logic                busy_ff, busy_in;
         logic                half_ff, half_in;
         logic                done_ff, done_in;
         logic [CNT_W-1:0]    cnt_ff, cnt_in;
         logic [FRAME_W-1:0]  rem_ff, rem_in;
         logic [PAD_W-1:0]    val_ff, val_in;
         logic [X_W-1:0]      x_ff, x_in;
         logic [X_W-1:0]      q_ff, q_in;
         logic [X_W-1:0]      x_cur;
         logic [2*X_W-1:0]    prod;
         logic [X_W-1:0]      diff;

         always_comb begin
            x_cur = {rem_ff, val_ff[PAD_W-1 -: CHUNK]};
            prod  = (2*X_W)'(x_cur) * (2*X_W)'(RECIP);
            diff  = x_ff - q_ff * X_W'(NUM_FRAMES);
         end

         always_comb begin
            busy_in = busy_ff;
            half_in = half_ff;
            done_in = 1'b0;
            cnt_in  = cnt_ff;
            rem_in  = rem_ff;
            val_in  = val_ff;
            x_in    = x_ff;
            q_in    = q_ff;
            if (start) begin
               busy_in = 1'b1;
               half_in = 1'b0;
               cnt_in  = '0;
               rem_in  = '0;
               val_in  = PAD_W'(value);
            end else if (busy_ff) begin
               if (!half_ff) begin
                  x_in    = x_cur;
                  q_in    = prod[2*X_W-1:X_W];
                  half_in = 1'b1;
               end else begin
                  rem_in  = (diff >= X_W'(NUM_FRAMES)) ?
                            FRAME_W'(diff - X_W'(NUM_FRAMES)) : FRAME_W'(diff);
                  val_in  = val_ff << CHUNK;
                  half_in = 1'b0;
                  cnt_in  = cnt_ff + 1'b1;
                  if (cnt_ff == CNT_W'(CHUNKS - 1)) begin
                     busy_in = 1'b0;
                     done_in = 1'b1;
                  end
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               busy_ff <= 1'b0;
               half_ff <= 1'b0;
               done_ff <= 1'b0;
            end else begin
               busy_ff <= busy_in;
               half_ff <= half_in;
               done_ff <= done_in;
            end
         end

         always_ff @(posedge clock) begin
            cnt_ff <= cnt_in;
            rem_ff <= rem_in;
            val_ff <= val_in;
            x_ff   <= x_in;
            q_ff   <= q_in;
         end

         assign done   = done_ff;
         assign result = rem_ff;
      end
   endgenerate

endmodule

// File: hw/rtl/ptw_ctrl.sv
// Walk sequencer: clears the store, walks levels, allocates and zeroes frames.
// Depends on ptw_pkg and the two channel interfaces.
module ptw_ctrl #(
   parameter int NUM_FRAMES = 64,
   parameter int LEVELS     = 5,
   localparam int FRAME_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1,
   localparam int ADDR_W  = FRAME_W + ptw_pkg::INDEX_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [ptw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ptw_pkg::CSR_DATA_W-1:0]     csr_wdata,
   ptw_req_if.sink                            req,
   ptw_rsp_if.source                          rsp,
   output ptw_pkg::mem_ctl_type               mem_ctl,
   output logic [ADDR_W-1:0]                  mem_addr,
   output logic [ptw_pkg::ENTRY_W-1:0]        mem_wdata,
   input  logic [ptw_pkg::ENTRY_W-1:0]        mem_rdata,
   output logic                               mod_start,
   output logic [ptw_pkg::PPN_W-1:0]          mod_value,
   input  logic                               mod_done,
   input  logic [FRAME_W-1:0]                 mod_result
);

   localparam int DEPTH = NUM_FRAMES * (2 ** ptw_pkg::INDEX_BITS);
   localparam int NF_W  = ($clog2(NUM_FRAMES + 1) > ptw_pkg::CSR_DATA_W) ?
                          $clog2(NUM_FRAMES + 1) : ptw_pkg::CSR_DATA_W;
   localparam int LV_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int IB    = ptw_pkg::INDEX_BITS;

   ptw_pkg::state_type                state_ff, state_in;
   logic [ADDR_W-1:0]                 clr_ff, clr_in;
   logic [ptw_pkg::CSR_DATA_W-1:0]    root_ff, root_in;
   logic [NF_W-1:0]                   nf_ff, nf_in;
   logic                              rsp_valid_ff, rsp_valid_in;

   logic [ptw_pkg::OP_W-1:0]          op_ff, op_in;
   logic [ptw_pkg::VPN_W-1:0]         vpn_ff, vpn_in;
   logic [ptw_pkg::PPN_W-1:0]         ppn_ff, ppn_in;
   logic [LV_W-1:0]                   level_ff, level_in;
   logic [FRAME_W-1:0]                frame_ff, frame_in;
   logic [ADDR_W-1:0]                 addr_ff, addr_in;
   logic [IB-1:0]                     zidx_ff, zidx_in;
   logic                              res_found_ff, res_found_in;
   logic [ptw_pkg::PPN_W-1:0]         res_ppn_ff, res_ppn_in;
   logic                              res_status_ff, res_status_in;
   logic                              found_ff, found_in;
   logic [ptw_pkg::PPN_W-1:0]         rppn_ff, rppn_in;
   logic                              status_ff, status_in;

   logic                              req_ready;
   logic [IB-1:0]                     idx;
   logic                              last_level;

   always_comb begin
      idx = IB'(vpn_ff >> (IB * (LEVELS - 1 - int'(level_ff))));
   end

   assign last_level = (level_ff == LV_W'(LEVELS - 1));

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      root_in       = root_ff;
      nf_in         = nf_ff;
      rsp_valid_in  = rsp_valid_ff;
      op_in         = op_ff;
      vpn_in        = vpn_ff;
      ppn_in        = ppn_ff;
      level_in      = level_ff;
      frame_in      = frame_ff;
      addr_in       = addr_ff;
      zidx_in       = zidx_ff;
      res_found_in  = res_found_ff;
      res_ppn_in    = res_ppn_ff;
      res_status_in = res_status_ff;
      found_in      = found_ff;
      rppn_in       = rppn_ff;
      status_in     = status_ff;
      mem_ctl       = '0;
      mem_addr      = addr_ff;
      mem_wdata     = '0;
      mod_start     = 1'b0;
      mod_value     = ptw_pkg::PPN_W'(root_ff);
      req_ready     = 1'b0;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ptw_pkg::S_CLEAR: begin
            mem_ctl.wr = 1'b1;
            mem_addr   = clr_ff;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ptw_pkg::S_IDLE;
            end
         end
         ptw_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req.valid) begin
               op_in         = req.operation;
               vpn_in        = req.vpn;
               ppn_in        = req.ppn;
               level_in      = '0;
               res_found_in  = 1'b0;
               res_ppn_in    = '0;
               res_status_in = 1'b0;
               if (req.operation == ptw_pkg::OP_QUERY || req.operation == ptw_pkg::OP_MAP ||
                   req.operation == ptw_pkg::OP_UNMAP) begin
                  mod_start = 1'b1;
                  state_in  = ptw_pkg::S_MOD;
               end else begin
                  state_in = ptw_pkg::S_DONE;
               end
            end
         end
         ptw_pkg::S_MOD: begin
            if (mod_done) begin
               frame_in = mod_result;
               state_in = ptw_pkg::S_READ;
            end
         end
         ptw_pkg::S_READ: begin
            mem_ctl.rd = 1'b1;
            mem_addr   = {frame_ff, idx};
            addr_in    = {frame_ff, idx};
            state_in   = ptw_pkg::S_WAIT;
         end
         ptw_pkg::S_WAIT: begin
            if (!last_level) begin
               if (mem_rdata == '0) begin
                  if (op_ff == ptw_pkg::OP_QUERY) begin
                     state_in = ptw_pkg::S_DONE;
                  end else if (nf_ff >= NF_W'(NUM_FRAMES)) begin
                     res_status_in = 1'b1;
                     state_in      = ptw_pkg::S_DONE;
                  end else begin
                     zidx_in  = '0;
                     state_in = ptw_pkg::S_ZERO;
                  end
               end else begin
                  mod_start = 1'b1;
                  mod_value = mem_rdata[ptw_pkg::ENTRY_W-1:1];
                  level_in  = level_ff + 1'b1;
                  state_in  = ptw_pkg::S_MOD;
               end
            end else begin
               case (op_ff)
                  ptw_pkg::OP_QUERY: begin
                     res_found_in = mem_rdata[0];
                     res_ppn_in   = mem_rdata[0] ? mem_rdata[ptw_pkg::ENTRY_W-1:1] : '0;
                  end
                  ptw_pkg::OP_MAP: begin
                     mem_ctl.wr = 1'b1;
                     mem_wdata  = {ppn_ff, 1'b1};
                  end
                  ptw_pkg::OP_UNMAP: begin
                     mem_ctl.wr = 1'b1;
                     mem_wdata  = {mem_rdata[ptw_pkg::ENTRY_W-1:1], 1'b0};
                  end
                  default: begin
                  end
               endcase
               state_in = ptw_pkg::S_DONE;
            end
         end
         ptw_pkg::S_ZERO: begin
            mem_ctl.wr = 1'b1;
            mem_addr   = {nf_ff[FRAME_W-1:0], zidx_ff};
            zidx_in    = zidx_ff + 1'b1;
            if (zidx_ff == '1) begin
               state_in = ptw_pkg::S_LINK;
            end
         end
         ptw_pkg::S_LINK: begin
            mem_ctl.wr = 1'b1;
            mem_wdata  = ptw_pkg::ENTRY_W'({nf_ff, 1'b1});
            frame_in   = nf_ff[FRAME_W-1:0];
            nf_in      = nf_ff + 1'b1;
            level_in   = level_ff + 1'b1;
            state_in   = ptw_pkg::S_READ;
         end
         ptw_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               found_in     = res_found_ff;
               rppn_in      = res_ppn_ff;
               status_in    = res_status_ff;
               state_in     = ptw_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ptw_pkg::S_IDLE;
         end
      endcase

      if (csr_wr_en) begin
         case (csr_index)
            ptw_pkg::CSR_ROOT_FRAME: root_in = csr_wdata;
            ptw_pkg::CSR_FIRST_FREE: nf_in   = NF_W'(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptw_pkg::S_CLEAR;
         clr_ff       <= '0;
         root_ff      <= ptw_pkg::ROOT_RESET;
         nf_ff        <= NF_W'(ptw_pkg::FIRST_FREE_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         root_ff      <= root_in;
         nf_ff        <= nf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      vpn_ff        <= vpn_in;
      ppn_ff        <= ppn_in;
      level_ff      <= level_in;
      frame_ff      <= frame_in;
      addr_ff       <= addr_in;
      zidx_ff       <= zidx_in;
      res_found_ff  <= res_found_in;
      res_ppn_ff    <= res_ppn_in;
      res_status_ff <= res_status_in;
      found_ff      <= found_in;
      rppn_ff       <= rppn_in;
      status_ff     <= status_in;
   end

   assign req.ready      = req_ready;
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.found      = found_ff;
   assign rsp.result_ppn = rppn_ff;
   assign rsp.status     = status_ff;

endmodule

// File: hw/rtl/page_table_walker_top.sv
// Top level of the page table walker: sequencer, modulo unit and frame store.
// Depends on ptw_pkg, ptw_req_if, ptw_rsp_if, ptw_ctrl, ptw_mod and ptw_store.

// The walker keeps a radix page table of LEVELS levels, nine index bits each,
// in one single-port store of NUM_FRAMES frames by 512 entries; a request reads
// one entry per level from that store, and each read depends on the previous
// one. At each level the walker selects the frame, reads the entry and checks
// it; with a frame count that is not a power of two, the frame select also does
// the frame number reduction, twelve bits per step.
// Each intermediate frame allocated by map or unmap is zeroed one entry at a
// time and then linked, in place of the frame select of that level.
// After reset the store is zeroed one entry per cycle, all NUM_FRAMES * 512
// entries (32768 by default), and no request is taken until that pass ends;
// configuration writes are taken throughout.
module page_table_walker_top #(
   parameter int NUM_FRAMES = 64,
   parameter int LEVELS     = 5
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [ptw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ptw_pkg::CSR_DATA_W-1:0]     csr_wdata,
   ptw_req_if.sink                            req_bus,
   ptw_rsp_if.source                          rsp_bus
);

   localparam int FRAME_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam int ADDR_W  = FRAME_W + ptw_pkg::INDEX_BITS;
   localparam int DEPTH   = NUM_FRAMES * (2 ** ptw_pkg::INDEX_BITS);

   ptw_pkg::mem_ctl_type              mem_ctl;
   logic [ADDR_W-1:0]                 mem_addr;
   logic [ptw_pkg::ENTRY_W-1:0]       mem_wdata;
   logic [ptw_pkg::ENTRY_W-1:0]       mem_rdata;
   logic                              mod_start;
   logic [ptw_pkg::PPN_W-1:0]         mod_value;
   logic                              mod_done;
   logic [FRAME_W-1:0]                mod_result;

   ptw_ctrl #(
      .NUM_FRAMES (NUM_FRAMES),
      .LEVELS     (LEVELS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req        (req_bus),
      .rsp        (rsp_bus),
      .mem_ctl    (mem_ctl),
      .mem_addr   (mem_addr),
      .mem_wdata  (mem_wdata),
      .mem_rdata  (mem_rdata),
      .mod_start  (mod_start),
      .mod_value  (mod_value),
      .mod_done   (mod_done),
      .mod_result (mod_result)
   );

   ptw_mod #(
      .NUM_FRAMES (NUM_FRAMES)
   ) u_mod (
      .clock  (clock),
      .reset  (reset),
      .start  (mod_start),
      .value  (mod_value),
      .done   (mod_done),
      .result (mod_result)
   );

   ptw_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock (clock),
      .ctl   (mem_ctl),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

endmodule

// File: hw/rtl/ptw_checker.sv
// Port-level checks of the page table walker, bound to the top level.
// Depends on ptw_pkg, page_table_walker_top_macros.svh and page_table_walker_top.
`include "page_table_walker_top_macros.svh"

module ptw_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_found,
   input logic [ptw_pkg::PPN_W-1:0]   rsp_result_ppn,
   input logic                        rsp_status
);

   `PTW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_found) && $stable(rsp_result_ppn) && $stable(rsp_status))
   `PTW_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready)
   `PTW_ASSERT_IMPLY(a_found_ok, clock, reset, rsp_valid && rsp_found, !rsp_status)
   `PTW_ASSERT_IMPLY(a_miss_zero, clock, reset, rsp_valid && !rsp_found, rsp_result_ppn == '0)
   `PTW_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid && !req_ready)

endmodule

bind page_table_walker_top ptw_checker u_ptw_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_found      (rsp_bus.found),
   .rsp_result_ppn (rsp_bus.result_ppn),
   .rsp_status     (rsp_bus.status)
);
